[design/txtkv_pkg.sv]
// Package for the TXT record key/value parser.
// Holds the item and result types, the fixed key table and the codes.
// No dependencies.
package txtkv_pkg;

	localparam int NUM_KEYS = 11;
	localparam int KEY_MAX_CHARS = 10;
	localparam int RQ_DEPTH = 4;

	localparam logic OP_BEGIN = 1'b0;
	localparam logic OP_BYTE = 1'b1;

	localparam logic KIND_VALUE = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_ERROR = 1'b1;

	localparam logic [7:0] CHAR_EQUALS = 8'h3D;
	localparam logic [7:0] MIN_STRING_LEN = 8'd3;
	localparam logic [3:0] KEY_LEN_SAT = 4'd15;
	localparam logic [3:0] KEY_IDX_TXTVERS = 4'd0;

	// Key text is right-justified: the first character sits in the highest used byte.
	localparam logic [8*KEY_MAX_CHARS-1:0] KEY_TEXT [NUM_KEYS] = '{
		80'("txtvers"), 80'("parType"), 80'("forId"), 80'("forPar"),
		80'("trustId"), 80'("trustPar"), 80'("trustCurve"), 80'("type"),
		80'("trustNonce"), 80'("alg"), 80'("digest")
	};

	localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{
		4'd7, 4'd7, 4'd5, 4'd6, 4'd7, 4'd8, 4'd10, 4'd4, 4'd10, 4'd3, 4'd6
	};

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LEN,
		PH_KEY,
		PH_VAL
	} phase_t;

	typedef struct packed {
		logic        opcode;
		logic [15:0] total_size;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic       kind;
		logic [3:0] key_index;
		logic [7:0] value_byte;
		logic       last_of_value;
		logic       status;
		logic       txtvers_first;
	} result_t;

	// Up to two results come out of one item; when there is only one it is in slot 0.
	typedef struct packed {
		logic    push0;
		result_t res0;
		logic    push1;
		result_t res1;
	} result_pair_t;

	function automatic logic [7:0] key_char(input int k, input logic [3:0] pos);
		logic [8*KEY_MAX_CHARS-1:0] text;
		logic [3:0] len;
		logic [3:0] sh;
		text = KEY_TEXT[k];
		len = KEY_LEN[k];
		sh = len - 4'd1 - pos;
		if (pos >= len) begin
			return 8'h00;
		end
		return text[{sh, 3'b000} +: 8];
	endfunction

	function automatic result_t make_value(input logic [3:0] idx, input logic [7:0] b,
			input logic last);
		result_t r;
		r.kind = KIND_VALUE;
		r.key_index = idx;
		r.value_byte = b;
		r.last_of_value = last;
		r.status = STATUS_OK;
		r.txtvers_first = 1'b0;
		return r;
	endfunction

	function automatic result_t make_done(input logic st, input logic tf);
		result_t r;
		r.kind = KIND_DONE;
		r.key_index = 4'd0;
		r.value_byte = 8'd0;
		r.last_of_value = 1'b0;
		r.status = st;
		r.txtvers_first = tf;
		return r;
	endfunction

endpackage

[design/txtkv_parse_core.sv]
// Parse state and per-byte decode for the TXT record parser.
// One item in, up to two results out in the same cycle. Depends on txtkv_pkg.
module txtkv_parse_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  txtkv_pkg::item_t      item,
	output txtkv_pkg::result_pair_t results
);
	import txtkv_pkg::*;

	logic [15:0]         br_q, br_d;
	logic [7:0]          sr_q, sr_d;
	phase_t              ph_q, ph_d;
	logic [3:0]          kl_q, kl_d;
	logic [NUM_KEYS-1:0] cand_q, cand_d;
	logic [3:0]          cur_q, cur_d;
	logic                ven_q, ven_d;
	logic [NUM_KEYS-1:0] seen_q, seen_d;
	logic                fkp_q, fkp_d;
	logic                twf_q, twf_d;

	logic [15:0]         br_dec;
	logic [7:0]          sr_dec;
	logic [NUM_KEYS-1:0] match;
	logic [3:0]          sel;
	logic                done_now;
	logic                done_st;

	assign br_dec = br_q - 16'd1;
	assign sr_dec = sr_q - 8'd1;

	always_comb begin
		match = '0;
		sel = 4'd0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			match[i] = cand_q[i] && (KEY_LEN[i] == kl_q);
		end
		for (int i = NUM_KEYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				sel = 4'(i);
			end
		end
	end

	always_comb begin
		br_d = br_q;
		sr_d = sr_q;
		ph_d = ph_q;
		kl_d = kl_q;
		cand_d = cand_q;
		cur_d = cur_q;
		ven_d = ven_q;
		seen_d = seen_q;
		fkp_d = fkp_q;
		twf_d = twf_q;
		done_now = 1'b0;
		done_st = STATUS_OK;
		results = '0;

		if (item_valid) begin
			if (item.opcode == OP_BEGIN) begin
				br_d = item.total_size;
				seen_d = '0;
				fkp_d = 1'b1;
				twf_d = 1'b0;
				sr_d = 8'd0;
				kl_d = 4'd0;
				cand_d = '1;
				ven_d = 1'b0;
				cur_d = 4'd0;
				if (item.total_size == 16'd0) begin
					done_now = 1'b1;
				end else begin
					ph_d = PH_LEN;
				end
			end else begin
				case (ph_q)
					PH_IDLE: begin
					end
					PH_LEN: begin
						if (item.data_byte < MIN_STRING_LEN ||
								{8'd0, item.data_byte} >= br_q) begin
							done_now = 1'b1;
							done_st = STATUS_ERROR;
						end else begin
							sr_d = item.data_byte;
							br_d = br_dec;
							kl_d = 4'd0;
							cand_d = '1;
							ven_d = 1'b0;
							cur_d = 4'd0;
							ph_d = PH_KEY;
						end
					end
					PH_KEY: begin
						br_d = br_dec;
						sr_d = sr_dec;
						if (item.data_byte == CHAR_EQUALS) begin
							if (kl_q == 4'd0 || sr_dec == 8'd0) begin
								done_now = 1'b1;
								done_st = STATUS_ERROR;
							end else begin
								if (fkp_q) begin
									twf_d = match[KEY_IDX_TXTVERS];
									fkp_d = 1'b0;
								end
								if ((|match) && !seen_q[sel]) begin
									seen_d[sel] = 1'b1;
									ven_d = 1'b1;
									cur_d = sel;
								end
								ph_d = PH_VAL;
							end
						end else begin
							for (int i = 0; i < NUM_KEYS; i++) begin
								if (kl_q >= KEY_LEN[i] || key_char(i, kl_q) != item.data_byte) begin
									cand_d[i] = 1'b0;
								end
							end
							if (kl_q != KEY_LEN_SAT) begin
								kl_d = kl_q + 4'd1;
							end
							// A string with no '=' ends here and is skipped.
							if (sr_dec == 8'd0) begin
								fkp_d = 1'b0;
								if (br_dec == 16'd0) begin
									done_now = 1'b1;
								end else begin
									ph_d = PH_LEN;
								end
							end
						end
					end
					PH_VAL: begin
						br_d = br_dec;
						sr_d = sr_dec;
						if (ven_q) begin
							results.push0 = 1'b1;
							results.res0 = make_value(cur_q, item.data_byte, sr_dec == 8'd0);
						end
						if (sr_dec == 8'd0) begin
							ven_d = 1'b0;
							if (br_dec == 16'd0) begin
								done_now = 1'b1;
							end else begin
								ph_d = PH_LEN;
							end
						end
					end
					default: begin
					end
				endcase
			end

			if (done_now) begin
				ph_d = PH_IDLE;
				ven_d = 1'b0;
				if (results.push0) begin
					results.push1 = 1'b1;
					results.res1 = make_done(done_st, twf_d);
				end else begin
					results.push0 = 1'b1;
					results.res0 = make_done(done_st, twf_d);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			br_q <= 16'd0;
			sr_q <= 8'd0;
			ph_q <= PH_IDLE;
			kl_q <= 4'd0;
			cand_q <= '1;
			cur_q <= 4'd0;
			ven_q <= 1'b0;
			seen_q <= '0;
			fkp_q <= 1'b1;
			twf_q <= 1'b0;
		end else begin
			br_q <= br_d;
			sr_q <= sr_d;
			ph_q <= ph_d;
			kl_q <= kl_d;
			cand_q <= cand_d;
			cur_q <= cur_d;
			ven_q <= ven_d;
			seen_q <= seen_d;
			fkp_q <= fkp_d;
			twf_q <= twf_d;
		end
	end

endmodule

[design/txtkv_result_queue.sv]
// Small register queue for parser results: two pushes, one pop per cycle.
// Its head entry drives the output port directly. Depends on txtkv_pkg.
module txtkv_result_queue #(
	parameter int DEPTH = txtkv_pkg::RQ_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  txtkv_pkg::result_pair_t push,
	input  logic                    pop,
	output txtkv_pkg::result_t      head,
	output logic                    head_valid,
	output logic                    room_for_two
);
	import txtkv_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	result_t       mem_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] wp_next;
	logic [1:0]    n_push;
	logic          do_pop;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign wp_next = ptr_inc(wp_q);
	assign n_push = {1'b0, push.push0} + {1'b0, push.push1};
	assign head_valid = (count_q != '0);
	assign do_pop = pop && head_valid;
	assign head = mem_q[rp_q];
	assign room_for_two = (count_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wp_q] <= push.res0;
		end
		if (push.push1) begin
			mem_q[wp_next] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			if (push.push1) begin
				wp_q <= ptr_inc(wp_next);
			end else if (push.push0) begin
				wp_q <= wp_next;
			end
			if (do_pop) begin
				rp_q <= ptr_inc(rp_q);
			end
			count_q <= count_q + CW'(n_push) - CW'(do_pop);
		end
	end

endmodule

[design/txt_record_key_value_parser_top.sv]
// Top level of the DNS-SD TXT record key/value parser.
// Uses txtkv_pkg, txtkv_parse_core and txtkv_result_queue.
//
//   channel   handshake            payload
//   input     in_valid/in_ready    opcode, total_size, data_byte
//   output    out_valid/out_ready  kind, key_index, value_byte, last_of_value,
//                                  status, txtvers_first
//
// One item per cycle is accepted while the result queue has space for two results.
// A transfer lands in the input register; the parse logic decodes it once the queue
// has space for two results and writes up to two results into the queue, whose
// head result is offered on the output port.
// The output port drains one result per cycle while out_ready is high, so a byte that
// also ends the record (value plus done) gives the output side two results to drain.
// Reset clears the parse state and the queue at once; no clearing pass is needed.
// Output stalls fill the queue and then hold in_ready low.
module txt_record_key_value_parser_top #(
	parameter int QUEUE_DEPTH = txtkv_pkg::RQ_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [15:0] total_size,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [3:0]  key_index,
	output logic [7:0]  value_byte,
	output logic        last_of_value,
	output logic        status,
	output logic        txtvers_first
);
	import txtkv_pkg::*;

	item_t        item_s1;
	logic         valid_s1;
	logic         room;
	logic         proc;
	result_pair_t pair;
	result_t      head;

	assign proc = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.opcode <= opcode;
			item_s1.total_size <= total_size;
			item_s1.data_byte <= data_byte;
		end
	end

	txtkv_parse_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (proc),
		.item       (item_s1),
		.results    (pair)
	);

	txtkv_result_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (pair),
		.pop          (out_ready),
		.head         (head),
		.head_valid   (out_valid),
		.room_for_two (room)
	);

	assign kind = head.kind;
	assign key_index = head.key_index;
	assign value_byte = head.value_byte;
	assign last_of_value = head.last_of_value;
	assign status = head.status;
	assign txtvers_first = head.txtvers_first;

endmodule

[design/txtkv_checker.sv]
// Port-level checks for the TXT record parser, bound to the top level.
// Depends on txtkv_pkg and txt_record_key_value_parser_top.
module txtkv_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       kind,
	input logic [3:0] key_index,
	input logic [7:0] value_byte,
	input logic       last_of_value,
	input logic       status,
	input logic       txtvers_first
);
	import txtkv_pkg::*;

	// A result that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output result dropped while stalled");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DONE |->
			key_index == 4'd0 && value_byte == 8'd0 && last_of_value == 1'b0)
		else $error("done result carries value fields");

	a_value_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_VALUE |-> status == STATUS_OK && txtvers_first == 1'b0)
		else $error("value result carries done fields");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_VALUE |-> key_index < 4'(NUM_KEYS))
		else $error("key index outside the key table");

endmodule

bind txt_record_key_value_parser_top txtkv_checker u_txtkv_checker (.*);

[tb/txt_record_key_value_parser_top_tb.sv]
// Self-checking testbench for the DNS-SD TXT record key/value parser.
// Depends on txtkv_pkg and txt_record_key_value_parser_top; predicts every
// value and done result from its own model of the record parser.
module txt_record_key_value_parser_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import txtkv_pkg::*;

	localparam int KEY_COUNT = 11;
	localparam int SHORTEST_STRING = 3;
	localparam int KEY_LEN_LIMIT = 15;
	localparam int LONG_HOLD = 300;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        opcode = OP_BEGIN;
	logic [15:0] total_size = '0;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [3:0]  key_index;
	logic [7:0]  value_byte;
	logic        last_of_value;
	logic        status;
	logic        txtvers_first;

	txt_record_key_value_parser_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .total_size(total_size), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .key_index(key_index), .value_byte(value_byte),
		.last_of_value(last_of_value), .status(status), .txtvers_first(txtvers_first)
	);

	string key_names [KEY_COUNT] = '{
		"txtvers", "parType", "forId", "forPar", "trustId", "trustPar",
		"trustCurve", "type", "trustNonce", "alg", "digest"
	};

	// Parser state as the block should hold it.
	logic [15:0] rec_bytes_rem = '0;
	logic [7:0]  str_left = '0;
	phase_t      rec_phase = PH_IDLE;
	logic [3:0]  key_len_cnt = '0;
	logic [10:0] candidates = '1;
	logic [3:0]  cur_key = '0;
	logic        val_en = 1'b0;
	logic [10:0] seen_keys = '0;
	logic        first_pending = 1'b1;
	logic        tv_first = 1'b0;

	item_t   pending_items [$];
	result_t parsed_results [$];
	int      items_queued = 0;
	int      failures = 0;
	int      tx_idle_pct = 0;
	int      rx_stall_pct = 0;
	int      rx_cycle = 0;
	int      hold_from = -1;
	logic    in_fire;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void clear_string();
		key_len_cnt = '0;
		candidates = '1;
		val_en = 1'b0;
		cur_key = '0;
	endfunction

	function automatic void close_record(logic st);
		result_t r;
		r = '0;
		r.kind = KIND_DONE;
		r.status = st;
		r.txtvers_first = tv_first;
		parsed_results.push_back(r);
		rec_phase = PH_IDLE;
		val_en = 1'b0;
	endfunction

	function automatic void parse_txt_item(item_t it);
		logic [7:0]  b;
		logic [10:0] hit;
		result_t     r;
		b = it.data_byte;
		if (it.opcode == OP_BEGIN) begin
			rec_bytes_rem = it.total_size;
			seen_keys = '0;
			first_pending = 1'b1;
			tv_first = 1'b0;
			str_left = '0;
			clear_string();
			if (rec_bytes_rem == 0)
				close_record(STATUS_OK);
			else
				rec_phase = PH_LEN;
			return;
		end
		if (rec_phase == PH_IDLE)
			return;
		if (rec_phase == PH_LEN) begin
			if (b < SHORTEST_STRING || b >= rec_bytes_rem) begin
				close_record(STATUS_ERROR);
			end else begin
				str_left = b;
				rec_bytes_rem--;
				clear_string();
				rec_phase = PH_KEY;
			end
			return;
		end
		rec_bytes_rem--;
		str_left--;
		if (rec_phase == PH_KEY) begin
			if (b == CHAR_EQUALS) begin
				if (key_len_cnt == 0 || str_left == 0) begin
					close_record(STATUS_ERROR);
					return;
				end
				hit = '0;
				for (int i = 0; i < KEY_COUNT; i++)
					if (candidates[i] && key_names[i].len() == key_len_cnt)
						hit[i] = 1'b1;
				if (first_pending) begin
					tv_first = hit[0];
					first_pending = 1'b0;
				end
				for (int i = 0; i < KEY_COUNT; i++) begin
					if (hit[i]) begin
						if (!seen_keys[i]) begin
							seen_keys[i] = 1'b1;
							val_en = 1'b1;
							cur_key = i[3:0];
						end
						break;
					end
				end
				rec_phase = PH_VAL;
				return;
			end
			for (int i = 0; i < KEY_COUNT; i++)
				if (key_len_cnt >= key_names[i].len() || key_names[i][key_len_cnt] != b)
					candidates[i] = 1'b0;
			if (key_len_cnt < KEY_LEN_LIMIT)
				key_len_cnt++;
			if (str_left == 0) begin
				first_pending = 1'b0;
				if (rec_bytes_rem == 0)
					close_record(STATUS_OK);
				else
					rec_phase = PH_LEN;
			end
			return;
		end
		if (val_en) begin
			r = '0;
			r.kind = KIND_VALUE;
			r.key_index = cur_key;
			r.value_byte = b;
			r.last_of_value = (str_left == 0);
			parsed_results.push_back(r);
		end
		if (str_left == 0) begin
			val_en = 1'b0;
			if (rec_bytes_rem == 0)
				close_record(STATUS_OK);
			else
				rec_phase = PH_LEN;
		end
	endfunction

	function automatic void log_failure(string what, result_t want, result_t got);
		failures++;
		if (failures <= 10)
			$display({"%0t %s: expected kind=%0d key=%0d byte=%02h last=%0d st=%0d tvf=%0d,",
				" got kind=%0d key=%0d byte=%02h last=%0d st=%0d tvf=%0d"},
				$realtime, what, want.kind, want.key_index, want.value_byte,
				want.last_of_value, want.status, want.txtvers_first,
				got.kind, got.key_index, got.value_byte, got.last_of_value,
				got.status, got.txtvers_first);
	endfunction

	function automatic void push_begin(logic [15:0] sz);
		item_t it;
		it.opcode = OP_BEGIN;
		it.total_size = sz;
		it.data_byte = 8'($urandom_range(0, 255));
		pending_items.push_back(it);
		items_queued++;
	endfunction

	function automatic void push_byte(logic [7:0] b);
		item_t it;
		it.opcode = OP_BYTE;
		it.total_size = 16'($urandom_range(0, 65535));
		it.data_byte = b;
		pending_items.push_back(it);
		items_queued++;
	endfunction

	function automatic logic [7:0] non_equals_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == CHAR_EQUALS)
			b = 8'h7E;
		return b;
	endfunction

	// Builds one record of up to four strings. Most records are well formed; some
	// carry a bad length byte, a wrong total size or are cut short by the next begin.
	task automatic queue_random_record();
		logic [7:0]  body [$];
		logic [7:0]  chunk [$];
		logic [7:0]  kbytes [$];
		int          len_pos [$];
		int          nstr;
		int          sel;
		logic [15:0] size;
		string       kname;
		nstr = $urandom_range(1, 4);
		for (int s = 0; s < nstr; s++) begin
			chunk = {};
			kbytes = {};
			sel = $urandom_range(0, 19);
			kname = key_names[$urandom_range(0, KEY_COUNT - 1)];
			if (s == 0 && $urandom_range(0, 2) == 0)
				kname = key_names[0];
			if ((sel >= 15 && sel <= 16) || sel == 19) begin
				repeat ($urandom_range(SHORTEST_STRING, sel == 19 ? 24 : 8))
					chunk.push_back(non_equals_byte());
			end else begin
				if (sel >= 12 && sel <= 14) begin
					case ($urandom_range(0, 2))
						0: kname = kname.substr(0, kname.len() - 2);
						1: kname = {kname, "s"};
						default: kname = "";
					endcase
					if (kname.len() == 0)
						repeat ($urandom_range(1, 20))
							kbytes.push_back(non_equals_byte());
				end
				foreach (kname[j])
					kbytes.push_back(kname[j]);
				// An empty key drops the key, an empty value ends at the '='.
				if (sel != 17)
					chunk = kbytes;
				chunk.push_back(CHAR_EQUALS);
				if (sel != 18)
					repeat ($urandom_range(sel == 17 ? 2 : 1, 6))
						chunk.push_back(8'($urandom_range(0, 255)));
			end
			len_pos.push_back(body.size());
			body.push_back(8'(chunk.size()));
			body = {body, chunk};
		end
		size = 16'(body.size());
		case ($urandom_range(0, 11))
			0: body[len_pos[$urandom_range(0, len_pos.size() - 1)]] = 8'($urandom_range(0, 2));
			1: body[len_pos[$urandom_range(0, len_pos.size() - 1)]] =
					8'($urandom_range(size, 255));
			2: size = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
					: 16'($urandom_range(0, body.size() + 3));
			3: body = body[0:$urandom_range(0, body.size() - 2)];
			default: ;
		endcase
		push_begin(size);
		foreach (body[j])
			push_byte(body[j]);
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3))
				push_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic wait_all_parsed();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || in_valid || parsed_results.size() != 0);
	endtask

	always @(negedge clk) begin : sender
		item_t nxt;
		if (arst_n && (!in_valid || in_fire)) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				nxt = pending_items.pop_front();
				in_valid <= 1'b1;
				opcode <= nxt.opcode;
				total_size <= nxt.total_size;
				data_byte <= nxt.data_byte;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		rx_cycle <= rx_cycle + 1;
		if (hold_from >= 0 && rx_cycle >= hold_from && rx_cycle < hold_from + LONG_HOLD)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		item_t   took;
		result_t got;
		result_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				took = {opcode, total_size, data_byte};
				parse_txt_item(took);
			end
			if (out_valid && out_ready) begin
				got = {kind, key_index, value_byte, last_of_value, status, txtvers_first};
				if (parsed_results.size() == 0) begin
					log_failure("result with none pending", '0, got);
				end else begin
					want = parsed_results.pop_front();
					if (got.kind !== want.kind || got.key_index !== want.key_index ||
							got.value_byte !== want.value_byte ||
							got.last_of_value !== want.last_of_value ||
							got.status !== want.status ||
							got.txtvers_first !== want.txtvers_first)
						log_failure("mismatch", want, got);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		tx_idle_pct = 12;
		rx_stall_pct = 73;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_byte(8'hA5);                         // byte with no record open
		push_begin(16'd0);                        // empty record ends at once
		push_begin(16'hFFFF);
		push_byte(8'd2);                          // length below the minimum
		push_begin(16'd4);
		push_byte(8'd4);                          // length reaches past the record
		push_begin(16'hFFFF);
		push_byte(8'd3);
		push_byte(CHAR_EQUALS);                   // empty key
		push_begin(16'd4);
		push_byte(8'd3);
		push_byte("a");
		push_byte("b");
		push_byte(CHAR_EQUALS);                   // empty value
		push_begin(16'h8000);
		push_byte(8'd4);
		push_byte("t");                           // abandoned by the next begin
		push_begin(16'd6);
		push_byte(8'd5);
		push_byte("a");
		push_byte("l");
		push_byte("g");
		push_byte(CHAR_EQUALS);
		push_byte(8'hFF);                         // last value byte also ends the record
		while (items_queued < 150)
			queue_random_record();
		wait_all_parsed();

		tx_idle_pct = 73;
		rx_stall_pct = 12;
		while (items_queued < 280)
			queue_random_record();
		wait_all_parsed();

		// The receiver stops for a long stretch while the sender keeps offering items.
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_from = rx_cycle + 1;
		while (items_queued < 420)
			queue_random_record();
		wait_all_parsed();

		repeat (16) @(posedge clk);
		if (parsed_results.size() != 0) begin
			failures++;
			$display("%0d expected results never arrived", parsed_results.size());
		end
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
design/txtkv_pkg.sv
design/txtkv_parse_core.sv
design/txtkv_result_queue.sv
design/txt_record_key_value_parser_top.sv
design/txtkv_checker.sv
tb/txt_record_key_value_parser_top_tb.sv
